>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the LFO block, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define LWD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define LWD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define LWD_ASSERT(lbl, prop, msg)
`define LWD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/lwd_pkg.sv
// Types, field layout and constants of the wavetable LFO.
package lwd_pkg;

    // Wave table and phase cursor
    localparam int TBL_AW     = 10;
    localparam int TABLE_SIZE = 1 << TBL_AW;
    localparam int FRAC_W     = 16;
    localparam int CUR_W      = TBL_AW + FRAC_W;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 10;
    localparam int SMP_W   = 16;
    localparam int TIME_W  = 24;
    localparam int FRAME_W = 10;
    localparam int MAG_W   = 16;
    localparam int RATE_W  = 16;
    localparam int OUT_W   = 19;

    // Stream payload layout
    localparam int TD_IDX_LSB   = 0;
    localparam int TD_SMP_LSB   = TD_IDX_LSB + IDX_W;
    localparam int TD_NOTE_LSB  = TD_SMP_LSB + SMP_W;
    localparam int TD_FRAME_LSB = TD_NOTE_LSB + TIME_W;
    localparam int TD_ZC_BIT    = TD_FRAME_LSB + FRAME_W;
    localparam int S_TDATA_W    = ((TD_ZC_BIT + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((OUT_W + 7) / 8) * 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TABLE_WR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_SYNC = 3'd5;

    localparam logic [MAG_W-1:0]  MAG_RESET  = 16'd16384;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

    // Shared multiplier and serial divider
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int P_W        = 32;
    localparam int ATT_SHIFT  = 29;
    localparam int DIV_K      = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_K);
    localparam int QUOT_W     = DIV_K + 1;

    typedef struct packed {
        logic [TIME_W-1:0]       delay_time;
        logic [TIME_W-1:0]       attack_time;
        logic [MAG_W-1:0]        magnitude;
        logic signed [SMP_W-1:0] base_value;
        logic [RATE_W-1:0]       rate;
        logic                    note_sync;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> hdl/wavetable_lfo_with_delay_attack_top.sv
// Wavetable LFO with delay and attack: sequencer, wave table and datapath.
// Table write and note-on transactions leave the block idle; a tick blocks the input until it completes.
// A tick in the delay or attack phase runs the serial divider once; its value reaches the
// output register through S_DLY_WAIT (delay) or S_ATK_WAIT and S_SCALE (attack), then S_OUT.
// A full output register holds the tick in its output state; ticks never overlap.
// Synchronous active-low reset clears state, output valid, cursor and held sample and loads config defaults;
// wave table contents stay undefined until written.
`include "assert_macros.svh"
module wavetable_lfo_with_delay_attack_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // table_index, table_sample, note_time, frame_time, zero_centered
    input  logic [lwd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind
    input  logic [lwd_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // lfo_value
    output logic [lwd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [lwd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lwd_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);
    import lwd_pkg::*;

    localparam int SCL_W  = PROD_W - ATT_SHIFT;
    localparam int SUM_W  = SCL_W + 1;
    localparam int DLY_W  = QUOT_W + 1;
    localparam int STEP_W = FRAME_W + RATE_W + TBL_AW;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_P, S_ATK_DIV, S_ATK_WAIT, S_SCALE, S_DLY_DIV, S_DLY_WAIT,
        S_OUT, S_RD_A, S_RD_B, S_INTERP, S_SAMPLE, S_STEP
    } t_state;

    t_state                  r_state;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;
    logic [OUT_W-1:0]        r_val;
    logic [CUR_W-1:0]        r_cursor;
    logic signed [SMP_W-1:0] r_sample;
    logic signed [SMP_W-1:0] r_a;
    logic [TIME_W-1:0]       r_note;
    logic [FRAME_W-1:0]      r_frame;
    logic                    r_zc;

    logic signed [SMP_W-1:0] r_wave [TABLE_SIZE];
    logic signed [SMP_W-1:0] r_rd_data;
    logic [TBL_AW-1:0]       w_rd_addr;

    t_cfg                    w_cfg;
    t_div_stat               w_div_stat;
    logic signed [QUOT_W-1:0] w_quot;
    logic                    w_div_start;
    logic [TIME_W-1:0]       w_divisor;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;

    logic                    w_s_acc;
    logic [IDX_W-1:0]        w_idx;
    logic signed [SMP_W-1:0] w_smp;
    logic                    w_idx_ok;
    logic                    w_active;
    logic [TIME_W-1:0]       w_t;
    logic                    w_in_attack;
    logic signed [PROD_W-1:0] w_shift;
    logic signed [SUM_W-1:0] w_sum;
    logic                    w_ovf;
    logic [OUT_W-1:0]        w_sat;
    logic signed [DLY_W-1:0] w_dly;
    logic signed [SMP_W-1:0] w_sample_next;
    logic [STEP_W-1:0]       w_step;
    logic [CUR_W-1:0]        w_cur_next;

    lwd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_cfg_wr_en),
        .i_index   (i_cfg_index),
        .i_wr_data (i_cfg_wr_data),
        .o_cfg     (w_cfg)
    );

    lwd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    lwd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_idx      = i_s_tdata[TD_IDX_LSB +: IDX_W];
    assign w_smp      = $signed(i_s_tdata[TD_SMP_LSB +: SMP_W]);
    assign w_idx_ok   = (32'(w_idx) < TABLE_SIZE);

    assign w_active    = (r_note > w_cfg.delay_time);
    assign w_t         = r_note - w_cfg.delay_time;
    assign w_in_attack = (w_t < w_cfg.attack_time);

    assign w_div_start = (r_state == S_ATK_DIV) || (r_state == S_DLY_DIV);
    assign w_divisor   = (r_state == S_ATK_DIV) ? w_cfg.attack_time : w_cfg.delay_time;

    // Operand selection for the shared multiplier; the product is registered and lands in the following cycle.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_EVAL: begin
                if (w_active) begin
                    w_mul_a = MUL_A_W'(r_sample);
                    w_mul_b = MUL_B_W'(w_cfg.magnitude);
                end else begin
                    w_mul_a = MUL_A_W'(w_cfg.base_value);
                    w_mul_b = MUL_B_W'(r_note);
                end
            end
            S_P: begin
                w_mul_a = MUL_A_W'($signed(w_prod[P_W-1:0]));
                if (w_in_attack) begin
                    w_mul_b = MUL_B_W'(w_t);
                end else begin
                    w_mul_b = MUL_B_W'(w_cfg.base_value);
                end
            end
            S_ATK_WAIT: begin
                w_mul_a = w_quot;
                w_mul_b = MUL_B_W'(w_cfg.base_value);
            end
            S_INTERP: begin
                w_mul_a = MUL_A_W'(r_rd_data) - MUL_A_W'(r_a);
                w_mul_b = MUL_B_W'(r_cursor[FRAC_W-1:0]);
            end
            S_SAMPLE: begin
                w_mul_a = MUL_A_W'(r_frame);
                w_mul_b = MUL_B_W'(w_cfg.rate);
            end
            default: ;
        endcase
    end

    // Scaled active value: floor(p*base / 2^29), offset and saturate.
    assign w_shift = w_prod >>> ATT_SHIFT;
    assign w_sum   = SUM_W'($signed(w_shift[SCL_W-1:0]))
                   + (r_zc ? SUM_W'(0) : SUM_W'(w_cfg.base_value));
    assign w_ovf   = !((&w_sum[SUM_W-1:OUT_W-1]) || !(|w_sum[SUM_W-1:OUT_W-1]));
    assign w_sat   = !w_ovf ? w_sum[OUT_W-1:0]
                   : (w_sum[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                     : {1'b0, {(OUT_W-1){1'b1}}});

    // Delay ramp, mirrored against the base when zero centered.
    assign w_dly = r_zc ? (DLY_W'(w_cfg.base_value) - DLY_W'(w_quot)) : DLY_W'(w_quot);

    // a + floor((b - a) * frac / 2^16)
    assign w_sample_next = r_a + $signed(w_prod[FRAC_W +: SMP_W]);

    // frame_time * rate * TABLE_SIZE / 4, taken modulo the cursor range
    assign w_step     = {w_prod[FRAME_W+RATE_W-1:0], {TBL_AW{1'b0}}} >> 2;
    assign w_cur_next = r_cursor + w_step[CUR_W-1:0];

    assign w_rd_addr = (r_state == S_RD_A) ? r_cursor[CUR_W-1:FRAC_W]
                                           : r_cursor[CUR_W-1:FRAC_W] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_s_acc && (i_s_tuser == KIND_TABLE_WR) && w_idx_ok) begin
            r_wave[TBL_AW'(w_idx)] <= w_smp;
        end
        r_rd_data <= r_wave[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cursor    <= '0;
            r_sample    <= '0;
        end else begin
            // drop valid on a taken transaction unless a new value loads this cycle
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_note  <= i_s_tdata[TD_NOTE_LSB +: TIME_W];
                        r_frame <= i_s_tdata[TD_FRAME_LSB +: FRAME_W];
                        r_zc    <= i_s_tdata[TD_ZC_BIT];
                        unique case (i_s_tuser)
                            KIND_NOTE_ON: begin
                                if (w_cfg.note_sync) begin
                                    r_cursor <= '0;
                                end
                            end
                            KIND_TICK: r_state <= S_EVAL;
                            default: ;
                        endcase
                    end
                end
                S_EVAL: begin
                    priority if (w_active) begin
                        r_state <= S_P;
                    end else if (w_cfg.delay_time != '0) begin
                        r_state <= S_DLY_DIV;
                    end else begin
                        r_val   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_P:        r_state <= w_in_attack ? S_ATK_DIV : S_SCALE;
                S_ATK_DIV:  r_state <= S_ATK_WAIT;
                S_ATK_WAIT: begin
                    if (w_div_stat.done) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_val   <= w_sat;
                    r_state <= S_OUT;
                end
                S_DLY_DIV:  r_state <= S_DLY_WAIT;
                S_DLY_WAIT: begin
                    if (w_div_stat.done) begin
                        r_val   <= w_dly[OUT_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_val;
                        r_state     <= S_RD_A;
                    end
                end
                S_RD_A: r_state <= S_RD_B;
                S_RD_B: begin
                    r_a     <= r_rd_data;
                    r_state <= S_INTERP;
                end
                S_INTERP: r_state <= S_SAMPLE;
                S_SAMPLE: begin
                    r_sample <= w_sample_next;
                    r_state  <= S_STEP;
                end
                S_STEP: begin
                    r_cursor <= w_cur_next;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_data);

    `LWD_ASSERT(a_div_start_idle, w_div_start |-> !w_div_stat.busy, "divider started while busy")
    `LWD_ASSERT(a_div_nonzero, w_div_start |-> (w_divisor != '0), "division by zero started")
    `LWD_ASSERT(a_tick_blocks, (w_s_acc && (i_s_tuser == KIND_TICK)) |=> !o_s_tready, "tick did not block input")
    `LWD_ASSERT(a_cursor_move, !$stable(r_cursor) |-> (($past(r_state) == S_STEP) || $past(w_s_acc)), "cursor moved outside step or note-on")
    `LWD_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

>>> hdl/lwd_regs.sv
// Configuration registers of the LFO.
module lwd_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [lwd_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [lwd_pkg::CFG_DATA_W-1:0] i_wr_data,
    output lwd_pkg::t_cfg                  o_cfg
);
    import lwd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_time  <= '0;
            r_cfg.attack_time <= '0;
            r_cfg.magnitude   <= MAG_RESET;
            r_cfg.base_value  <= '0;
            r_cfg.rate        <= RATE_RESET;
            r_cfg.note_sync   <= 1'b0;
        end else if (i_wr_en) begin
            unique case (i_index)
                CFG_DELAY:     r_cfg.delay_time  <= i_wr_data[TIME_W-1:0];
                CFG_ATTACK:    r_cfg.attack_time <= i_wr_data[TIME_W-1:0];
                CFG_MAGNITUDE: r_cfg.magnitude   <= i_wr_data[MAG_W-1:0];
                CFG_BASE:      r_cfg.base_value  <= $signed(i_wr_data[SMP_W-1:0]);
                CFG_RATE:      r_cfg.rate        <= i_wr_data[RATE_W-1:0];
                CFG_NOTE_SYNC: r_cfg.note_sync   <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/lwd_mul.sv
// Shared signed multiplier with registered product.
module lwd_mul (
    input  logic                              i_clk,
    input  logic signed [lwd_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [lwd_pkg::MUL_B_W-1:0] i_b,
    output logic signed [lwd_pkg::PROD_W-1:0]  o_prod
);
    import lwd_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> hdl/lwd_div.sv
// Serial restoring divider, one quotient bit a cycle, floor rounding.
module lwd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [lwd_pkg::PROD_W-1:0]  i_dividend,
    input  logic [lwd_pkg::TIME_W-1:0]         i_divisor,
    output lwd_pkg::t_div_stat                 o_stat,
    output logic signed [lwd_pkg::QUOT_W-1:0]  o_quot
);
    import lwd_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} t_dstate;

    t_dstate               r_state;
    logic                  r_done;
    logic                  r_neg;
    logic [TIME_W-1:0]     r_rem;
    logic [TIME_W-1:0]     r_dvs;
    logic [DIV_K-1:0]      r_shq;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [QUOT_W-1:0]     r_quot;

    logic [PROD_W-1:0]     w_mag;
    logic [TIME_W:0]       w_trial;
    logic [TIME_W:0]       w_diff;
    logic                  w_ge;
    logic [QUOT_W-1:0]     w_qinc;

    // The quotient is known to fit DIV_K bits, so the top of the dividend
    // already sits below the divisor and seeds the partial remainder.
    assign w_mag   = i_dividend[PROD_W-1] ? PROD_W'(-i_dividend) : i_dividend;
    assign w_trial = {r_rem, r_shq[DIV_K-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_qinc  = {1'b0, r_shq} + QUOT_W'(r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_dividend[PROD_W-1];
                        r_rem   <= w_mag[DIV_K +: TIME_W];
                        r_shq   <= w_mag[DIV_K-1:0];
                        r_dvs   <= i_divisor;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= w_ge ? w_diff[TIME_W-1:0] : w_trial[TIME_W-1:0];
                    r_shq <= {r_shq[DIV_K-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_K - 1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    // round toward minus infinity for a negative dividend
                    r_quot  <= r_neg ? -w_qinc : {1'b0, r_shq};
                    r_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != D_IDLE);
    assign o_stat.done = r_done;
    assign o_quot      = $signed(r_quot);

endmodule

>>> test/lfo_value_checker.sv
`timescale 1ns / 1ps
// Watches the LFO stream and config ports, predicts every tick value and compares it.
module lfo_value_checker
    import lwd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // table_index, table_sample, note_time, frame_time, zero_centered
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // kind
    input  logic [KIND_W-1:0]     i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // lfo_value
    input  logic [M_TDATA_W-1:0]  i_m_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_ticks_checked
);

    localparam longint OUT_HI = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< (OUT_W - 1));

    logic signed [SMP_W-1:0] wave_mem [TABLE_SIZE];
    logic [CUR_W-1:0]        cursor;
    logic signed [SMP_W-1:0] held_sample;
    logic [TIME_W-1:0]       delay_r;
    logic [TIME_W-1:0]       attack_r;
    logic [MAG_W-1:0]        mag_r;
    logic signed [SMP_W-1:0] base_r;
    logic [RATE_W-1:0]       rate_r;
    logic                    sync_r;
    logic [OUT_W-1:0]        lfo_expected_q [$];

    function automatic longint floor_quot(longint x, longint d);
        if (x >= 0) return x / d;
        return -((-x + d - 1) / d);
    endfunction

    // Value emitted by a tick, from the sample held since the previous tick.
    function automatic logic [OUT_W-1:0] tick_value(logic [TIME_W-1:0] nt, logic zc);
        longint p;
        longint r;
        longint t;
        longint base;
        base = longint'(base_r);
        if (nt > delay_r) begin
            p = longint'(held_sample) * longint'(mag_r);
            t = longint'(nt) - longint'(delay_r);
            // fade in while the attack is still running
            if (t < longint'(attack_r))
                p = floor_quot(p * t, longint'(attack_r));
            r = (p * base) >>> ATT_SHIFT;
            if (!zc)
                r += base;
            if (r > OUT_HI)
                r = OUT_HI;
            if (r < OUT_LO)
                r = OUT_LO;
        end else if (delay_r != '0) begin
            r = floor_quot(base * longint'(nt), longint'(delay_r));
            if (zc)
                r = base - r;
        end else begin
            r = 0;
        end
        return r[OUT_W-1:0];
    endfunction

    // Interpolate the next held sample, then move the cursor on by one frame.
    function automatic void advance_cursor(logic [FRAME_W-1:0] ft);
        logic [TBL_AW-1:0] idx_a;
        logic [TBL_AW-1:0] idx_b;
        longint frac;
        longint mix;
        longint step;
        idx_a = cursor[CUR_W-1:FRAC_W];
        idx_b = idx_a + 1'b1;
        frac  = longint'(cursor[FRAC_W-1:0]);
        mix   = longint'(wave_mem[idx_a]) * ((longint'(1) <<< FRAC_W) - frac)
              + longint'(wave_mem[idx_b]) * frac;
        held_sample = mix[SMP_W+FRAC_W-1:FRAC_W];
        step   = (longint'(ft) * longint'(rate_r) * TABLE_SIZE) >>> 2;
        // cursor width makes the wrap around the table implicit
        cursor = cursor + step[CUR_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] got;
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            cursor          = '0;
            held_sample     = '0;
            delay_r         = '0;
            attack_r        = '0;
            mag_r           = MAG_RESET;
            base_r          = '0;
            rate_r          = RATE_RESET;
            sync_r          = 1'b0;
            o_fail_count    = 0;
            o_ticks_checked = 0;
            lfo_expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[OUT_W-1:0];
                if (lfo_expected_q.size() == 0) begin
                    $error("lfo_value: expected none, actual %0d", $signed(got));
                    o_fail_count++;
                end else begin
                    want = lfo_expected_q.pop_front();
                    o_ticks_checked++;
                    if (got !== want) begin
                        $error("lfo_value: expected %0d, actual %0d",
                               $signed(want), $signed(got));
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser)
                    KIND_TABLE_WR: begin
                        wave_mem[i_s_tdata[TD_IDX_LSB +: IDX_W]] = i_s_tdata[TD_SMP_LSB +: SMP_W];
                    end
                    KIND_NOTE_ON: begin
                        if (sync_r)
                            cursor = '0;
                    end
                    KIND_TICK: begin
                        lfo_expected_q.push_back(tick_value(i_s_tdata[TD_NOTE_LSB +: TIME_W],
                                                            i_s_tdata[TD_ZC_BIT]));
                        advance_cursor(i_s_tdata[TD_FRAME_LSB +: FRAME_W]);
                    end
                    default: ;
                endcase
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DELAY:     delay_r  = i_cfg_wr_data[TIME_W-1:0];
                    CFG_ATTACK:    attack_r = i_cfg_wr_data[TIME_W-1:0];
                    CFG_MAGNITUDE: mag_r    = i_cfg_wr_data[MAG_W-1:0];
                    CFG_BASE:      base_r   = i_cfg_wr_data[SMP_W-1:0];
                    CFG_RATE:      rate_r   = i_cfg_wr_data[RATE_W-1:0];
                    CFG_NOTE_SYNC: sync_r   = i_cfg_wr_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = lfo_expected_q.size();
    end

endmodule

>>> test/tb_wavetable_lfo_with_delay_attack_top.sv
`timescale 1ns / 1ps
// Testbench top for the wavetable LFO: stimulus, config phases, handshake pacing and verdict.
module tb_wavetable_lfo_with_delay_attack_top;
    import lwd_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI   = 3'd7;
    localparam int                   TIME_MAX       = (1 << TIME_W) - 1;
    localparam int                   MAX_WAIT       = 17;
    localparam int                   SETTLE_CYCLES  = 60;
    localparam int                   CYCLE_LIMIT    = 1_500_000;
    localparam int                   RANDOM_ITEMS   = 560;
    localparam int                   RANDOM_PHASES  = 8;
    localparam int                   PRESSURE_AFTER = 200;
    localparam int                   PRESSURE_HOLD  = 700;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic [KIND_W-1:0]     i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;

    int fail_count;
    int pending;
    int ticks_checked;
    int cycle_count    = 0;
    int items_sent     = 0;
    int settings_used  = 0;

    logic [TIME_W-1:0] delay_cur;
    logic [TIME_W-1:0] attack_cur;

    wavetable_lfo_with_delay_attack_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    lfo_value_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_ticks_checked (ticks_checked)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, stall-free stretches and one long hold-off.
    initial begin : result_sink
        int stall;
        int taken;
        bit held_off;
        taken      = 0;
        held_off   = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held_off && taken >= PRESSURE_AFTER) begin
                // hold off long enough for the block to back up into its input
                held_off = 1'b1;
                i_m_tready <= 1'b0;
                repeat (PRESSURE_HOLD) @(negedge i_clk);
            end
            stall = ((taken / 64) % 3 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            taken++;
            @(negedge i_clk);
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(logic [IDX_W-1:0] idx,
                                                       logic [SMP_W-1:0] smp,
                                                       logic [TIME_W-1:0] nt,
                                                       logic [FRAME_W-1:0] ft,
                                                       logic zc);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[TD_IDX_LSB +: IDX_W]     = idx;
        d[TD_SMP_LSB +: SMP_W]     = smp;
        d[TD_NOTE_LSB +: TIME_W]   = nt;
        d[TD_FRAME_LSB +: FRAME_W] = ft;
        d[TD_ZC_BIT]               = zc;
        return d;
    endfunction

    function automatic logic [S_TDATA_W-1:0] random_bits();
        return {$urandom, $urandom};
    endfunction

    // Offer one transaction after a random gap; called and returns at a falling edge.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [S_TDATA_W-1:0] payload);
        int gap;
        gap = ((items_sent / 48) % 4 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tuser  <= kind;
        i_s_tdata  <= payload;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    // Fields that the kind ignores carry random bits.
    task automatic send_table_write(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] smp);
        send_item(KIND_TABLE_WR, pack_item(idx, smp, TIME_W'($urandom), FRAME_W'($urandom),
                                           1'($urandom_range(0, 1))));
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] nt, input logic [FRAME_W-1:0] ft,
                             input logic zc);
        send_item(KIND_TICK, pack_item(IDX_W'($urandom), SMP_W'($urandom), nt, ft, zc));
    endtask

    // Drop valid, drain all results, then let the block finish any silent work.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [TIME_W-1:0] dly, input logic [TIME_W-1:0] atk,
                                 input logic [MAG_W-1:0] mag, input logic [SMP_W-1:0] base,
                                 input logic [RATE_W-1:0] rt, input logic sync);
        write_reg(CFG_DELAY, CFG_DATA_W'(dly));
        write_reg(CFG_ATTACK, CFG_DATA_W'(atk));
        write_reg(CFG_MAGNITUDE, CFG_DATA_W'(mag));
        write_reg(CFG_BASE, CFG_DATA_W'(base));
        write_reg(CFG_RATE, CFG_DATA_W'(rt));
        write_reg(CFG_NOTE_SYNC, CFG_DATA_W'(sync));
        // unmapped index last, so any aliasing would corrupt a live register
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
        i_cfg_wr_en <= 1'b0;
        delay_cur  = dly;
        attack_cur = atk;
        settings_used++;
    endtask

    task automatic run_random(input int n);
        int start;
        int r;
        int len;
        logic [TIME_W-1:0]  nt;
        logic [FRAME_W-1:0] ft;
        logic               zc;
        longint             aim;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // note: note-on, then ticks whose note time advances by the frame time
                send_item(KIND_NOTE_ON, random_bits());
                nt  = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom) : '0;
                zc  = 1'($urandom_range(0, 1));
                len = $urandom_range(3, 12);
                repeat (len) begin
                    ft = FRAME_W'($urandom);
                    send_tick(nt, ft, zc);
                    aim = longint'(nt) + longint'(ft);
                    nt  = (aim > TIME_MAX) ? TIME_W'(TIME_MAX) : aim[TIME_W-1:0];
                end
            end else if (r < 82) begin
                send_table_write(IDX_W'($urandom), SMP_W'($urandom));
            end else if (r < 94) begin
                // lone tick aimed at the delay and attack boundaries, the time extremes or a random time
                case ($urandom_range(0, 7))
                    0: aim = longint'(delay_cur) - 1;
                    1: aim = longint'(delay_cur);
                    2: aim = longint'(delay_cur) + 1;
                    3: aim = longint'(delay_cur) + longint'(attack_cur) - 1;
                    4: aim = longint'(delay_cur) + longint'(attack_cur);
                    5: aim = 0;
                    6: aim = TIME_MAX;
                    default: aim = longint'(TIME_W'($urandom));
                endcase
                if (aim < 0)
                    aim = 0;
                if (aim > TIME_MAX)
                    aim = TIME_MAX;
                send_tick(aim[TIME_W-1:0], FRAME_W'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                send_item(KIND_UNUSED, random_bits());
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = KIND_TABLE_WR;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_DELAY;
        i_cfg_wr_data = '0;
        delay_cur     = '0;
        attack_cur    = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short delay and attack so that one note crosses both
        load_settings(24'd64, 24'd128, MAG_RESET, 16'sd16000, RATE_RESET, 1'b1);
        // fill the whole table before any tick reads it
        for (int i = 0; i < TABLE_SIZE; i++)
            send_table_write(IDX_W'(i), SMP_W'($urandom));

        send_table_write('0, 16'h8000);
        send_table_write(IDX_W'(TABLE_SIZE - 1), 16'h7FFF);
        send_item(KIND_UNUSED, random_bits());
        send_item(KIND_NOTE_ON, random_bits());
        send_tick(24'd0, 10'd0, 1'b0);
        send_tick(24'd0, 10'd0, 1'b1);
        send_tick(24'd32, 10'd1023, 1'b1);
        send_tick(24'd64, 10'd300, 1'b0);
        send_tick(24'd65, 10'd512, 1'b0);
        send_tick(24'd128, 10'd777, 1'b1);
        send_tick(24'd192, 10'd1, 1'b0);
        send_tick(TIME_W'(TIME_MAX), 10'd1023, 1'b1);

        wait_idle();
        load_settings(24'd0, 24'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b0);
        send_tick(24'd0, 10'd5, 1'b0);
        send_tick(24'd0, 10'd1023, 1'b1);
        send_item(KIND_NOTE_ON, random_bits());
        send_tick(24'd1, 10'd1023, 1'b0);
        send_tick(24'd1, 10'd1023, 1'b1);
        send_tick(TIME_W'(TIME_MAX), 10'd0, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: load_settings('0, '0, MAG_W'($urandom), SMP_W'($urandom),
                                 RATE_W'($urandom_range(0, 2048)), 1'b1);
                1: load_settings(TIME_W'(TIME_MAX), TIME_W'(TIME_MAX), '0, 16'h7FFF, '0, 1'b0);
                2: load_settings(TIME_W'($urandom_range(0, 255)), TIME_W'(TIME_MAX), 16'hFFFF,
                                 16'h8000, 16'hFFFF, 1'b1);
                default: load_settings(TIME_W'($urandom_range(0, 3000)),
                                       TIME_W'($urandom_range(0, 3000)),
                                       MAG_W'($urandom), SMP_W'($urandom), RATE_W'($urandom),
                                       1'($urandom_range(0, 1)));
            endcase
            run_random(RANDOM_ITEMS / RANDOM_PHASES);
        end
        wait_idle();

        $display("Run: %0d stream transactions sent, %0d tick values checked",
                 items_sent, ticks_checked);
        $display("Run: %0d register settings, register extremes and unmapped indexes included",
                 settings_used);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
